// ===== rtl/earliest_free_worker_scheduler_unit_macros.svh =====
// Assertion helpers shared by the scheduler RTL.
`ifndef EARLIEST_FREE_WORKER_SCHEDULER_UNIT_MACROS_SVH
`define EARLIEST_FREE_WORKER_SCHEDULER_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define EFWS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define EFWS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/efws_pkg.sv =====
package efws_pkg;

  // Built worker count and the widths that follow from the item fields.
  localparam int unsigned MAX_WORKERS = 16;
  localparam int unsigned ADDR_W      = $clog2(MAX_WORKERS);
  localparam int unsigned WIDX_W      = 4;
  localparam int unsigned CNT_W       = 5;
  localparam int unsigned DUR_W       = 31;
  localparam int unsigned TIME_W      = 63;

  typedef logic [TIME_W-1:0] time_t;
  typedef logic [DUR_W-1:0]  dur_t;
  typedef logic [CNT_W-1:0]  cnt_t;

endpackage

// ===== rtl/earliest_free_worker_scheduler_unit.sv =====
// Channel | Direction | Handshake              | Payload
// --------+-----------+------------------------+------------------------------
// in      | input     | in_valid_i / in_stall_o | job_duration_i (31 bits)
// out     | output    | out_valid_o / out_stall_i | worker_index_o, start_time_o
// cfg     | input     | cfg_we_i               | cfg_wdata_i (worker count)
//
// A job that starts a fresh worker goes from acceptance straight to S_DONE.
// Any other job first sweeps every started worker in S_SCAN, then S_UPD:
// the single read port of the finish-time memory is swept once per job.
// One job is in work at a time; the next job is taken while a result still
// waits in the output register.
// Reset clears the control state and sets the worker count to one; the
// finish-time memory is not cleared, since only written entries are read.

`include "earliest_free_worker_scheduler_unit_macros.svh"

module earliest_free_worker_scheduler_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [efws_pkg::CNT_W-1:0]     cfg_wdata_i,
  // job input
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [efws_pkg::DUR_W-1:0]     job_duration_i,
  // result output
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [efws_pkg::WIDX_W-1:0]    worker_index_o,
  output logic [efws_pkg::TIME_W-1:0]    start_time_o
);

  // Sequencer codes.
  localparam logic [1:0] S_IDLE = 2'd0;  // wait for a job
  localparam logic [1:0] S_SCAN = 2'd1;  // sweep finish times for the minimum
  localparam logic [1:0] S_UPD  = 2'd2;  // write back the new finish time
  localparam logic [1:0] S_DONE = 2'd3;  // hand the result to the output register

  localparam int unsigned AW = efws_pkg::ADDR_W;

  logic [1:0]            state_q, state_d;
  efws_pkg::cnt_t        wcount_q;
  efws_pkg::cnt_t        started_q, started_d;
  efws_pkg::cnt_t        eff_count;
  efws_pkg::dur_t        dur_q, dur_d;
  logic [AW-1:0]         rd_idx_q, rd_idx_d;
  efws_pkg::time_t       min_q, min_d;
  logic [AW-1:0]         chosen_q, chosen_d;
  logic                  out_valid_q;
  logic [efws_pkg::WIDX_W-1:0] out_idx_q;
  efws_pkg::time_t       out_time_q;

  // Finish-time memory: one write port, one registered read port.
  efws_pkg::time_t       mem_q [efws_pkg::MAX_WORKERS];
  efws_pkg::time_t       rdata_q;
  logic [AW-1:0]         rd_addr;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  efws_pkg::time_t       wr_data;

  logic                  in_accept;
  logic                  out_free;
  logic                  scan_last;
  logic                  take_min;
  efws_pkg::time_t       finish_sum;

  assign in_accept = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  // Zero counts as one worker; anything past the built count saturates.
  always_comb begin
    if (wcount_q == '0) begin
      eff_count = efws_pkg::cnt_t'(1);
    end else if (wcount_q > efws_pkg::cnt_t'(efws_pkg::MAX_WORKERS)) begin
      eff_count = efws_pkg::cnt_t'(efws_pkg::MAX_WORKERS);
    end else begin
      eff_count = wcount_q;
    end
  end

  // Data in rdata_q belongs to entry rd_idx_q during the sweep.
  assign scan_last  = (efws_pkg::cnt_t'(rd_idx_q) + efws_pkg::cnt_t'(1)) == started_q;
  assign take_min   = (rd_idx_q == '0) || (rdata_q < min_q);
  assign finish_sum = min_q + efws_pkg::time_t'(dur_q);

  always_comb begin
    state_d   = state_q;
    started_d = started_q;
    dur_d     = dur_q;
    rd_idx_d  = rd_idx_q;
    min_d     = min_q;
    chosen_d  = chosen_q;
    rd_addr   = rd_idx_q + AW'(1);
    wr_en     = 1'b0;
    wr_addr   = chosen_q;
    wr_data   = finish_sum;

    unique case (state_q)
      S_IDLE: begin
        rd_addr = '0;
        if (in_accept) begin
          dur_d = job_duration_i;
          if (started_q < eff_count) begin
            // Start the next fresh worker at time zero.
            chosen_d  = started_q[AW-1:0];
            min_d     = '0;
            started_d = started_q + efws_pkg::cnt_t'(1);
            wr_en     = 1'b1;
            wr_addr   = started_q[AW-1:0];
            wr_data   = efws_pkg::time_t'(job_duration_i);
            state_d   = S_DONE;
          end else begin
            // Entry 0 is being read now; sweep from there.
            rd_idx_d = '0;
            state_d  = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (take_min) begin
          min_d    = rdata_q;
          chosen_d = rd_idx_q;
        end
        if (scan_last) begin
          state_d = S_UPD;
        end else begin
          rd_idx_d = rd_idx_q + AW'(1);
        end
      end
      S_UPD: begin
        // Write back ahead of any read of the next job: no overlap possible.
        wr_en   = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      started_q   <= '0;
      wcount_q    <= efws_pkg::cnt_t'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      started_q <= started_d;
      if (cfg_we_i) begin
        wcount_q <= cfg_wdata_i;
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk_i) begin
    dur_q    <= dur_d;
    rd_idx_q <= rd_idx_d;
    min_q    <= min_d;
    chosen_q <= chosen_d;
    if (state_q == S_DONE && out_free) begin
      out_idx_q  <= efws_pkg::WIDX_W'(chosen_q);
      out_time_q <= min_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rdata_q <= mem_q[rd_addr];
  end

  assign out_valid_o    = out_valid_q;
  assign worker_index_o = out_idx_q;
  assign start_time_o   = out_time_q;

  `EFWS_ASSERT_ALWAYS(a_started_bound, started_q <= efws_pkg::cnt_t'(efws_pkg::MAX_WORKERS), "started workers exceed built count")
  `EFWS_ASSERT(a_scan_in_range, (state_q == S_SCAN) |-> (efws_pkg::cnt_t'(rd_idx_q) < started_q), "sweep reads an unstarted worker")
  `EFWS_ASSERT(a_upd_to_done, (state_q == S_UPD) |=> (state_q == S_DONE), "write-back not followed by result")
  `EFWS_ASSERT(a_chosen_started, (state_q == S_UPD) |-> (efws_pkg::cnt_t'(chosen_q) < started_q), "chosen worker never started")

endmodule
